// ----- rtl/core/vnt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_pkg: shared types and constants for value noise turbulence
// Fixed-point widths, operation and register codes, divider status.
// ----------------------------------------------------------------------------
package vnt_pkg;

	localparam int VAL_W   = 17;	// Q1.16 value, 0..1.0
	localparam int FRAC_W  = 16;
	localparam int COORD_W = 32;	// Q16.16 coordinate
	localparam int CFG_W   = 5;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_W   = MUL_A_W + MUL_B_W;

	localparam logic [VAL_W-1:0]   ONE_Q16    = 17'h10000;
	localparam logic [COORD_W-1:0] OFFSET_Q16 = 32'd1669202;	// 25.47
	localparam logic [MUL_B_W-1:0] THREE_Q16  = 18'h30000;
	localparam logic [MUL_W-1:0]   HALF_32    = 51'h80000000;
	localparam logic [MUL_W-1:0]   HALF_16    = 51'h8000;

	typedef enum logic [1:0] {
		OP_LOAD_NOISE = 2'd0,
		OP_LOAD_PERM  = 2'd1,
		OP_EVAL       = 2'd2
	} op_t;

	typedef enum logic {
		CFG_OCTAVES = 1'b0,
		CFG_DIM     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/vnt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnt_div: iterative restoring divider
// One quotient bit per cycle; quotient known to fit VAL_W bits.
// ----------------------------------------------------------------------------
module vnt_div
	import vnt_pkg::*;
#(
	parameter int NUM_W = 32,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat,
	output logic [VAL_W-1:0] quot
);

	localparam int CNT_W = $clog2(VAL_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [VAL_W-1:0] low_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		rem_sh = {rem_q, low_q[VAL_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> VAL_W);
			low_q <= num[VAL_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			low_q <= {low_q[VAL_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = low_q;

endmodule

// ----- rtl/core/value_noise_turbulence.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_turbulence: fractal value noise, 1D or 2D
// Table loads, and point evaluation through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready) carries one transaction: a noise-table
//  load, a permutation-table load or a point evaluation. Loads are written
//  in the accept cycle and produce no result. An evaluation produces one
//  noise_value on the output channel (out_valid/out_ready).
//  Config port (cfg_we/cfg_index/cfg_data) sets the octave count and the
//  dimension mode; write it only while no evaluation is in flight.
//  An evaluation runs its octaves one after another, 1D or 2D, then a final
//  normalization divide and result load. Every octave step runs through a
//  single 33x18 multiplier and one read port per table, which is why each
//  octave is split into steps; the divide yields one quotient bit per cycle.
//  in_ready is low while an evaluation runs; a load leaves it high.
//  The result sits in an output register, so new transactions are taken
//  while it waits; a following evaluation holds in its last step until the
//  receiver takes the previous result.
//  Reset sets octave_count to 1 and dimension_mode to 2D. Table contents are
//  undefined until loaded.
// ----------------------------------------------------------------------------
module value_noise_turbulence
	import vnt_pkg::*;
#(
	parameter int TABLE_BITS  = 10,
	parameter int MAX_OCTAVES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               operation,
	input  logic [9:0]               table_index,
	input  logic [VAL_W-1:0]         table_value,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VAL_W-1:0]         noise_value,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int TB    = TABLE_BITS;
	localparam int DEPTH = 1 << TB;
	localparam int DEN_W = MAX_OCTAVES;
	localparam int ACC_W = FRAC_W + MAX_OCTAVES;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SX_SQ, ST_SX_CUB, ST_SY_SQ, ST_SY_CUB,
		ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
		ST_W1, ST_P1, ST_W2, ST_P2, ST_W3, ST_P3, ST_FIN,
		ST_L0, ST_L1, ST_L2,
		ST_DIV_GO, ST_DIV_WAIT, ST_DONE
	} state_t;

	state_t           state_q;
	logic             out_valid_q;
	logic [CFG_W-1:0] octave_count_q;
	logic             dimension_mode_q;
	logic [CFG_W-1:0] oct_left_q;

	logic [VAL_W-1:0] noise_mem_q [DEPTH];
	logic [TB-1:0]    perm_mem_q  [DEPTH];
	logic [VAL_W-1:0] noise_rd_q;
	logic [TB-1:0]    perm_rd_q;

	logic [COORD_W-1:0] x_q, y_q;
	logic [VAL_W-1:0]   sx_q, sy_q;
	logic [TB-1:0]      px0_q, px1_q;
	logic [TB-1:0]      h0_q, h1_q, h2_q, h3_q;
	logic [VAL_W-1:0]   cv0_q, cv1_q, cv2_q, cv3_q;
	logic [MUL_W-1:0]   mul_q;
	logic [MUL_W-1:0]   sum_q;
	logic [ACC_W-1:0]   acc_q;
	logic [DEN_W-1:0]   den_q;
	logic [VAL_W-1:0]   noise_value_q;

	logic               in_accept;
	logic               oct_end;
	logic               out_load;
	logic               div_start;
	div_stat_t          div_stat;
	logic [VAL_W-1:0]   div_quot;
	logic [ACC_W-1:0]   div_num;
	logic [CFG_W-1:0]   oct_c;
	logic [DEN_W-1:0]   den_c;
	logic [TB-1:0]      wr_addr;
	logic [VAL_W-1:0]   wr_noise;
	logic [TB-1:0]      ix, ix1, iy, iy1;
	logic [FRAC_W-1:0]  fx, fy;
	logic [VAL_W-1:0]   wx0, wy0;
	logic [TB-1:0]      perm_addr, noise_addr;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_W-1:0]   mul_p;
	logic [MUL_W-1:0]   s_rnd;
	logic [MUL_W-1:0]   oct_sum;
	logic [VAL_W-1:0]   n_oct;
	logic [COORD_W-1:0] x_off, y_off;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign oct_end   = (state_q == ST_L2) || (state_q == ST_FIN);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign div_start = (state_q == ST_DIV_GO);
	assign out_valid   = out_valid_q;
	assign noise_value = noise_value_q;

	always_comb begin
		if (octave_count_q == '0)
			oct_c = CFG_W'(1);
		else if (octave_count_q > CFG_W'(MAX_OCTAVES))
			oct_c = CFG_W'(MAX_OCTAVES);
		else
			oct_c = octave_count_q;
		for (int j = 0; j < DEN_W; j++)
			den_c[j] = (CFG_W'(j) < oct_c);
	end

	assign wr_addr  = TB'(table_index);
	assign wr_noise = (table_value > ONE_Q16) ? ONE_Q16 : table_value;

	assign ix  = x_q[FRAC_W +: TB];
	assign iy  = y_q[FRAC_W +: TB];
	assign ix1 = ix + TB'(1);
	assign iy1 = iy + TB'(1);
	assign fx  = x_q[FRAC_W-1:0];
	assign fy  = y_q[FRAC_W-1:0];
	assign wx0 = ONE_Q16 - sx_q;
	assign wy0 = ONE_Q16 - sy_q;

	always_comb begin
		case (state_q)
			ST_SX_CUB: perm_addr = ix1;
			ST_SY_CUB: perm_addr = iy + px0_q;
			ST_H1:     perm_addr = iy + px1_q;
			ST_H2:     perm_addr = iy1 + px0_q;
			ST_H3:     perm_addr = iy1 + px1_q;
			default:   perm_addr = ix;
		endcase
		case (state_q)
			ST_SX_CUB: noise_addr = ix1;
			ST_H2:     noise_addr = h0_q;
			ST_H3:     noise_addr = h1_q;
			ST_H4:     noise_addr = h2_q;
			ST_H5:     noise_addr = h3_q;
			default:   noise_addr = ix;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_SX_SQ: begin
				mul_a = MUL_A_W'(fx);
				mul_b = MUL_B_W'(fx);
			end
			ST_SX_CUB: begin
				mul_a = {1'b0, mul_q[31:0]};
				mul_b = THREE_Q16 - {1'b0, fx, 1'b0};
			end
			ST_SY_SQ: begin
				mul_a = MUL_A_W'(fy);
				mul_b = MUL_B_W'(fy);
			end
			ST_SY_CUB: begin
				mul_a = {1'b0, mul_q[31:0]};
				mul_b = THREE_Q16 - {1'b0, fy, 1'b0};
			end
			ST_H5: begin
				mul_a = MUL_A_W'(wx0);
				mul_b = MUL_B_W'(wy0);
			end
			ST_H6: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cv0_q);
			end
			ST_W1: begin
				mul_a = MUL_A_W'(sx_q);
				mul_b = MUL_B_W'(wy0);
			end
			ST_P1: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cv1_q);
			end
			ST_W2: begin
				mul_a = MUL_A_W'(wx0);
				mul_b = MUL_B_W'(sy_q);
			end
			ST_P2: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cv2_q);
			end
			ST_W3: begin
				mul_a = MUL_A_W'(sx_q);
				mul_b = MUL_B_W'(sy_q);
			end
			ST_P3: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cv3_q);
			end
			ST_L0: begin
				mul_a = MUL_A_W'(wx0);
				mul_b = MUL_B_W'(cv0_q);
			end
			ST_L1: begin
				mul_a = MUL_A_W'(sx_q);
				mul_b = MUL_B_W'(cv1_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign s_rnd   = mul_q + HALF_32;
	assign oct_sum = sum_q + mul_q + ((state_q == ST_FIN) ? HALF_32 : HALF_16);
	assign n_oct   = (state_q == ST_FIN) ? oct_sum[48:32] : oct_sum[32:16];
	assign x_off   = x_q + OFFSET_Q16;
	assign y_off   = y_q + OFFSET_Q16;
	assign div_num = acc_q + ACC_W'(den_q >> 1);

	vnt_div #(
		.NUM_W(ACC_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (den_q),
		.stat  (div_stat),
		.quot  (div_quot)
	);

	// table memories, registered read
	always_ff @(posedge clk) begin
		if (in_accept && operation == OP_LOAD_NOISE)
			noise_mem_q[wr_addr] <= wr_noise;
		noise_rd_q <= noise_mem_q[noise_addr];
	end

	always_ff @(posedge clk) begin
		if (in_accept && operation == OP_LOAD_PERM)
			perm_mem_q[wr_addr] <= TB'(table_value);
		perm_rd_q <= perm_mem_q[perm_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			out_valid_q      <= 1'b0;
			octave_count_q   <= CFG_W'(1);
			dimension_mode_q <= 1'b1;
			oct_left_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_OCTAVES: octave_count_q <= cfg_data;
					CFG_DIM:     dimension_mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_accept && operation == OP_EVAL) begin
						oct_left_q <= oct_c;
						state_q    <= ST_SX_SQ;
					end
				end
				ST_SX_SQ:  state_q <= ST_SX_CUB;
				ST_SX_CUB: state_q <= ST_SY_SQ;
				ST_SY_SQ:  state_q <= dimension_mode_q ? ST_SY_CUB : ST_L0;
				ST_SY_CUB: state_q <= ST_H1;
				ST_H1:     state_q <= ST_H2;
				ST_H2:     state_q <= ST_H3;
				ST_H3:     state_q <= ST_H4;
				ST_H4:     state_q <= ST_H5;
				ST_H5:     state_q <= ST_H6;
				ST_H6:     state_q <= ST_W1;
				ST_W1:     state_q <= ST_P1;
				ST_P1:     state_q <= ST_W2;
				ST_W2:     state_q <= ST_P2;
				ST_P2:     state_q <= ST_W3;
				ST_W3:     state_q <= ST_P3;
				ST_P3:     state_q <= ST_FIN;
				ST_L0:     state_q <= ST_L1;
				ST_L1:     state_q <= ST_L2;
				ST_FIN, ST_L2: begin
					oct_left_q <= oct_left_q - CFG_W'(1);
					state_q    <= (oct_left_q == CFG_W'(1)) ? ST_DIV_GO : ST_SX_SQ;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_stat.done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (in_accept && operation == OP_EVAL) begin
			x_q   <= $unsigned(coord_x);
			y_q   <= $unsigned(coord_y);
			acc_q <= '0;
			den_q <= den_c;
		end
		case (state_q)
			ST_SX_CUB: begin
				px0_q <= perm_rd_q;
				cv0_q <= noise_rd_q;
			end
			ST_SY_SQ: begin
				sx_q  <= s_rnd[48:32];
				px1_q <= perm_rd_q;
				cv1_q <= noise_rd_q;
			end
			ST_H1: begin
				sy_q <= s_rnd[48:32];
				h0_q <= perm_rd_q;
			end
			ST_H2: h1_q <= perm_rd_q;
			ST_H3: begin
				h2_q  <= perm_rd_q;
				cv0_q <= noise_rd_q;
			end
			ST_H4: begin
				h3_q  <= perm_rd_q;
				cv1_q <= noise_rd_q;
			end
			ST_H5: cv2_q <= noise_rd_q;
			ST_H6: cv3_q <= noise_rd_q;
			ST_W1, ST_L1: sum_q <= mul_q;
			ST_W2, ST_W3: sum_q <= sum_q + mul_q;
			default: ;
		endcase
		if (oct_end) begin
			acc_q <= (acc_q << 1) + ACC_W'(n_oct);
			x_q   <= {x_off[COORD_W-2:0], 1'b0};
			y_q   <= {y_off[COORD_W-2:0], 1'b0};
		end
		if (out_load)
			noise_value_q <= (div_quot > ONE_Q16) ? ONE_Q16 : div_quot;
	end

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_WAIT))
		else $error("divider done outside wait step");

	a_eval_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && operation == OP_EVAL) |=> !in_ready)
		else $error("ready after evaluation accept");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (noise_value_q <= ONE_Q16))
		else $error("result above one");
`endif

endmodule

// ----- tb/value_noise_turbulence_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_turbulence_test: self-checking bench for value_noise_turbulence
// Fills both tables, then checks directed points at the reset setting and at
// the octave and mode extremes, then random loads and evaluations under
// several sender idle and receiver stall mixes. A local fixed-point model of
// the turbulence sum predicts every noise_value in transaction order.
// ----------------------------------------------------------------------------
module value_noise_turbulence_test;
	import vnt_pkg::*;

	localparam int IDX_BITS      = 10;
	localparam int TABLE_DEPTH   = 1 << IDX_BITS;
	localparam int OCT_LIMIT     = 16;
	localparam int HALF_PERIOD   = 4;
	localparam int DRAIN_CYCLES  = 320;
	localparam longint RUN_LIMIT_NS = 64'd40_000_000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [COORD_W-1:0] EDGE_COORDS [8] = '{
		32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
		32'h03FF_8000, 32'h0000_8000, 32'h0001_FFFF, 32'h0400_FFFF
	};

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic [1:0]                operation   = OP_EVAL;
	logic [IDX_BITS-1:0]       table_index = '0;
	logic [VAL_W-1:0]          table_value = '0;
	logic signed [COORD_W-1:0] coord_x     = '0;
	logic signed [COORD_W-1:0] coord_y     = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [VAL_W-1:0]          noise_value;
	logic                      cfg_we      = 1'b0;
	logic                      cfg_index   = CFG_OCTAVES;
	logic [CFG_W-1:0]          cfg_data    = '0;

	// local copy of the block state
	logic [VAL_W-1:0]    noise_mem [TABLE_DEPTH];
	logic [IDX_BITS-1:0] perm_mem [TABLE_DEPTH];
	logic [CFG_W-1:0]    octaves_q = 5'd1;
	logic                dim_q     = 1'b1;

	logic [VAL_W-1:0] expected_noise [$];
	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;

	value_noise_turbulence u_dut (.*);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic longint unsigned smooth_frac(input logic [FRAC_W-1:0] f);
		longint unsigned ff;
		ff = f;
		return (ff * ff * (64'(THREE_Q16) - 2 * ff) + (64'd1 << 31)) >> 32;
	endfunction

	function automatic longint unsigned lattice_1d(input logic [COORD_W-1:0] x);
		logic [IDX_BITS-1:0] ix0, ix1;
		longint unsigned s, a, b;
		ix0 = x[FRAC_W +: IDX_BITS];
		ix1 = ix0 + 1'b1;
		s = smooth_frac(x[FRAC_W-1:0]);
		a = noise_mem[ix0];
		b = noise_mem[ix1];
		return (a * (ONE_Q16 - s) + b * s + (64'd1 << 15)) >> 16;
	endfunction

	function automatic longint unsigned hashed_value(input logic [IDX_BITS-1:0] cx, cy);
		logic [IDX_BITS-1:0] slot;
		slot = cy + perm_mem[cx];
		return noise_mem[perm_mem[slot]];
	endfunction

	function automatic longint unsigned lattice_2d(input logic [COORD_W-1:0] x, y);
		logic [IDX_BITS-1:0] ix0, ix1, iy0, iy1;
		longint unsigned sx, sy, wx, wy;
		ix0 = x[FRAC_W +: IDX_BITS];
		iy0 = y[FRAC_W +: IDX_BITS];
		ix1 = ix0 + 1'b1;
		iy1 = iy0 + 1'b1;
		sx = smooth_frac(x[FRAC_W-1:0]);
		sy = smooth_frac(y[FRAC_W-1:0]);
		wx = ONE_Q16 - sx;
		wy = ONE_Q16 - sy;
		return (hashed_value(ix0, iy0) * wx * wy + hashed_value(ix1, iy0) * sx * wy
			+ hashed_value(ix0, iy1) * wx * sy + hashed_value(ix1, iy1) * sx * sy
			+ (64'd1 << 31)) >> 32;
	endfunction

	function automatic logic [VAL_W-1:0] predict_turbulence(input logic [COORD_W-1:0] x0, y0);
		logic [COORD_W-1:0] x, y;
		int oct, i;
		longint unsigned acc, den, res;
		x = x0;
		y = y0;
		oct = octaves_q;
		if (oct < 1)
			oct = 1;
		if (oct > OCT_LIMIT)
			oct = OCT_LIMIT;
		acc = 0;
		for (i = 0; i < oct; i++) begin
			acc += (dim_q ? lattice_2d(x, y) : lattice_1d(x)) << (oct - 1 - i);
			x = (x + OFFSET_Q16) << 1;
			y = (y + OFFSET_Q16) << 1;
		end
		den = (64'd1 << oct) - 1;
		res = (acc + (den >> 1)) / den;
		return (res > ONE_Q16) ? ONE_Q16 : res[VAL_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want, got);
		$display("%0t ns: MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// scoreboard: config, result check, then prediction of the new transaction
	always @(posedge clk) begin
		logic [VAL_W-1:0] want;
		if (cfg_we) begin
			if (cfg_index == CFG_OCTAVES)
				octaves_q = cfg_data;
			else
				dim_q = cfg_data[0];
		end
		if (out_valid && out_ready) begin
			if (expected_noise.size() == 0) begin
				report_mismatch("noise_value with no evaluation pending", '0, noise_value);
			end else begin
				want = expected_noise.pop_front();
				if (noise_value !== want)
					report_mismatch("noise_value", want, noise_value);
			end
		end
		if (in_valid && in_ready) begin
			case (operation)
				OP_LOAD_NOISE: noise_mem[table_index] =
					(table_value > ONE_Q16) ? ONE_Q16 : table_value;
				OP_LOAD_PERM: perm_mem[table_index] = table_value[IDX_BITS-1:0];
				OP_EVAL: expected_noise.push_back(predict_turbulence(coord_x, coord_y));
				default: ;
			endcase
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [IDX_BITS-1:0] idx,
		input logic [VAL_W-1:0] val, input logic [COORD_W-1:0] x, y);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		table_index <= idx;
		table_value <= val;
		coord_x     <= x;
		coord_y     <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] oct, input logic [CFG_W-1:0] dim);
		drain_pipeline();
		write_reg(CFG_OCTAVES, oct);
		write_reg(CFG_DIM, dim);
	endtask

	// every entry gets written before any evaluation can read it
	task automatic test_table_fill();
		logic [VAL_W-1:0] val;
		int i;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			case (i)
				0: val = '0;
				1: val = ONE_Q16;
				2: val = ONE_Q16 + 1'b1;
				3: val = '1;
				default: val = ($urandom_range(9) == 0) ? VAL_W'($urandom)
					: VAL_W'($urandom_range(65536));
			endcase
			send_item(OP_LOAD_NOISE, i[IDX_BITS-1:0], val, $urandom, $urandom);
		end
		for (i = 0; i < TABLE_DEPTH; i++)
			send_item(OP_LOAD_PERM, i[IDX_BITS-1:0], VAL_W'($urandom), $urandom, $urandom);
	endtask

	// one octave, 2D, as left by reset; unused opcode must give no result
	task automatic test_reset_setting();
		int k;
		for (k = 0; k < 8; k++)
			send_item(OP_EVAL, '0, '0, EDGE_COORDS[k], EDGE_COORDS[7-k]);
		send_item(OP_UNUSED, IDX_BITS'($urandom), VAL_W'($urandom), $urandom, $urandom);
		send_item(OP_EVAL, '0, '0, $urandom, $urandom);
	endtask

	// octave count 16 and 17 in 1D, 0 and 31 in 2D
	task automatic test_setting_extremes();
		apply_setting(5'd16, 5'b11110);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[1], EDGE_COORDS[2]);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[2], EDGE_COORDS[1]);
		apply_setting(5'd0, 5'b00001);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[3], EDGE_COORDS[4]);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[4], EDGE_COORDS[5]);
		apply_setting(5'd31, 5'b00001);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[6], EDGE_COORDS[7]);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[1], EDGE_COORDS[3]);
		apply_setting(5'd17, 5'b00000);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[5], EDGE_COORDS[0]);
		send_item(OP_EVAL, '0, '0, EDGE_COORDS[7], EDGE_COORDS[6]);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_level, input int count);
		int n, pick;
		logic [1:0] op;
		logic [CFG_W-1:0] oct;
		logic [VAL_W-1:0] val;
		logic [COORD_W-1:0] x, y;
		logic [FRAC_W-1:0] frac;
		send_idle_pct = idle_pct;
		stall_pct = stall_level;
		for (n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				pick = $urandom_range(9);
				if (pick < 7)
					oct = CFG_W'($urandom_range(1, 4));
				else if (pick < 9)
					oct = CFG_W'($urandom_range(5, 16));
				else
					oct = CFG_W'($urandom);
				apply_setting(oct, CFG_W'($urandom));
			end
			pick = $urandom_range(99);
			if (pick < 60)
				op = OP_EVAL;
			else if (pick < 78)
				op = OP_LOAD_NOISE;
			else if (pick < 95)
				op = OP_LOAD_PERM;
			else
				op = OP_UNUSED;
			val = ($urandom_range(9) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(65536));
			x = $urandom;
			y = $urandom;
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(2))
					0: frac = 16'h0000;
					1: frac = 16'h8000;
					default: frac = 16'hFFFF;
				endcase
				x[FRAC_W-1:0] = frac;
				y[FRAC_W-1:0] = frac;
			end
			send_item(op, IDX_BITS'($urandom), val, x, y);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_reset_setting();
		test_setting_extremes();
		test_random_traffic(0, 0, 500);
		test_random_traffic(58, 0, 500);
		test_random_traffic(0, 58, 500);
		test_random_traffic(22, 22, 500);
		drain_pipeline();
		if (mismatch_count == 0)
			$display("value_noise_turbulence_test passed");
		else
			$display("value_noise_turbulence_test failed");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout: %0d evaluations still pending", expected_noise.size());
		$display("value_noise_turbulence_test failed");
		$finish;
	end

endmodule
